>>> rtl/core/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// Shared constants and types for the WebSocket frame parser.
// ----------------------------------------------------------------------------
package wsfp_pkg;

	localparam logic [2:0] PH_HDR0    = 3'd0;
	localparam logic [2:0] PH_HDR1    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_MASK    = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CLOSED  = 3'd5;

	localparam logic [3:0] OPC_TEXT   = 4'd1;
	localparam logic [3:0] OPC_BINARY = 4'd2;
	localparam logic [3:0] OPC_CLOSE  = 4'd8;

	localparam logic [6:0] LEN_EXT16  = 7'd126;
	localparam logic [6:0] LEN_EXT64  = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;

	localparam logic EV_DATA  = 1'b0;
	localparam logic EV_CLOSE = 1'b1;

	typedef struct packed {
		logic       event_kind;
		logic [7:0] payload_byte;
		logic       is_binary;
		logic       last_of_frame;
	} wsfp_result_t;

endpackage

>>> rtl/core/websocket_frame_parser.sv
// ----------------------------------------------------------------------------
// websocket_frame_parser
// Receive-side WebSocket frame parser: one byte per word in, unmasked payload
// bytes and a close event out.
//
// Channel  Dir  Word                 tuser                         tlast
// s_       in   tdata[7:0] rx_byte   -                             -
// m_       out  tdata[7:0] payload   [0] event_kind [1] is_binary  last_of_frame
//
// One byte per cycle sustained while the output is not stalled; input register,
// decode, result register: each decoded result word is registered in the output buffer.
// Reset clears the frame state to expect a first header byte.
// s_tready depends only on local registers; a stalled output fills the skid
// stage, then the input register, then s_tready drops.
// ----------------------------------------------------------------------------
module websocket_frame_parser import wsfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] payload_byte
	output logic [1:0] m_tuser,   // [0] event_kind, [1] is_binary
	output logic       m_tlast
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         space;
	logic         step;
	logic         res_valid;
	wsfp_result_t res;
	wsfp_result_t m_data;

	assign step     = valid_s1 && space;
	assign s_tready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	wsfp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	wsfp_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (res_valid),
		.wr_data  (res),
		.space    (space),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_data   (m_data)
	);

	assign m_tdata = m_data.payload_byte;
	assign m_tuser = {m_data.is_binary, m_data.event_kind};
	assign m_tlast = m_data.last_of_frame;

endmodule

>>> rtl/core/wsfp_parse.sv
// ----------------------------------------------------------------------------
// wsfp_parse
// Frame state and per-byte decode: header, extended length, mask key, payload.
// ----------------------------------------------------------------------------
module wsfp_parse import wsfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,
	input  logic [7:0]   byte_s1,
	output logic         res_valid,
	output wsfp_result_t res
);

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  opcode_q, opcode_d;
	logic        masked_q, masked_d;
	logic [3:0]  ext_cnt_q, ext_cnt_d;
	logic [63:0] rem_q, rem_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  idx_q, idx_d;

	logic [63:0] rem_shift;
	logic [63:0] rem_dec;
	logic [3:0]  ext_cnt_dec;
	logic [1:0]  idx_inc;
	logic [7:0]  key_byte;
	logic [6:0]  len7;
	logic        data_frame;
	logic        emit;

	assign rem_shift   = {rem_q[55:0], byte_s1};
	assign rem_dec     = rem_q - 64'd1;
	assign ext_cnt_dec = ext_cnt_q - 4'd1;
	assign idx_inc     = idx_q + 2'd1;
	assign key_byte    = key_q[{~idx_q, 3'b000} +: 8];
	assign len7        = byte_s1[6:0];
	assign data_frame  = (opcode_q == OPC_TEXT) || (opcode_q == OPC_BINARY);

	always_comb begin
		phase_d   = phase_q;
		opcode_d  = opcode_q;
		masked_d  = masked_q;
		ext_cnt_d = ext_cnt_q;
		rem_d     = rem_q;
		key_d     = key_q;
		idx_d     = idx_q;
		emit      = 1'b0;
		res       = '0;
		unique case (phase_q)
			PH_CLOSED: begin
			end
			PH_HDR1: begin
				masked_d = byte_s1[7];
				if (len7 == LEN_EXT16) begin
					ext_cnt_d = EXT16_BYTES;
					rem_d     = '0;
					phase_d   = PH_EXTLEN;
				end else if (len7 == LEN_EXT64) begin
					ext_cnt_d = EXT64_BYTES;
					rem_d     = '0;
					phase_d   = PH_EXTLEN;
				end else begin
					ext_cnt_d = '0;
					rem_d     = {57'd0, len7};
					idx_d     = '0;
					if (byte_s1[7]) begin
						phase_d = PH_MASK;
					end else if (len7 != 7'd0) begin
						phase_d = PH_PAYLOAD;
					end else if (opcode_q == OPC_CLOSE) begin
						emit             = 1'b1;
						res.event_kind   = EV_CLOSE;
						phase_d          = PH_CLOSED;
					end else begin
						phase_d = PH_HDR0;
					end
				end
			end
			PH_EXTLEN: begin
				rem_d     = rem_shift;
				ext_cnt_d = ext_cnt_dec;
				if (ext_cnt_dec == 4'd0) begin
					idx_d = '0;
					if (masked_q) begin
						phase_d = PH_MASK;
					end else if (rem_shift != 64'd0) begin
						phase_d = PH_PAYLOAD;
					end else if (opcode_q == OPC_CLOSE) begin
						emit           = 1'b1;
						res.event_kind = EV_CLOSE;
						phase_d        = PH_CLOSED;
					end else begin
						phase_d = PH_HDR0;
					end
				end
			end
			PH_MASK: begin
				key_d = {key_q[23:0], byte_s1};
				idx_d = idx_inc;
				if (idx_inc == 2'd0) begin
					if (rem_q != 64'd0) begin
						phase_d = PH_PAYLOAD;
					end else if (opcode_q == OPC_CLOSE) begin
						emit           = 1'b1;
						res.event_kind = EV_CLOSE;
						phase_d        = PH_CLOSED;
					end else begin
						phase_d = PH_HDR0;
					end
				end
			end
			PH_PAYLOAD: begin
				idx_d = idx_inc;
				rem_d = rem_dec;
				if (data_frame) begin
					emit              = 1'b1;
					res.event_kind    = EV_DATA;
					res.payload_byte  = masked_q ? (byte_s1 ^ key_byte) : byte_s1;
					res.is_binary     = (opcode_q == OPC_BINARY);
					res.last_of_frame = (rem_dec == 64'd0);
					if (rem_dec == 64'd0) begin
						phase_d = PH_HDR0;
					end
				end else if (rem_dec == 64'd0) begin
					if (opcode_q == OPC_CLOSE) begin
						emit           = 1'b1;
						res.event_kind = EV_CLOSE;
						phase_d        = PH_CLOSED;
					end else begin
						phase_d = PH_HDR0;
					end
				end
			end
			default: begin
				opcode_d = byte_s1[3:0];
				phase_d  = PH_HDR1;
			end
		endcase
	end

	assign res_valid = step && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			opcode_q  <= '0;
			masked_q  <= 1'b0;
			ext_cnt_q <= '0;
			rem_q     <= '0;
			key_q     <= '0;
			idx_q     <= '0;
		end else if (step) begin
			phase_q   <= phase_d;
			opcode_q  <= opcode_d;
			masked_q  <= masked_d;
			ext_cnt_q <= ext_cnt_d;
			rem_q     <= rem_d;
			key_q     <= key_d;
			idx_q     <= idx_d;
		end
	end

	a_close_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_CLOSED |=> phase_q == PH_CLOSED)
		else $error("left closed phase");

	a_close_enters: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_kind == EV_CLOSE |=> phase_q == PH_CLOSED)
		else $error("close event without closed phase");

	a_data_in_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_kind == EV_DATA |-> phase_q == PH_PAYLOAD && data_frame)
		else $error("data word outside payload of data frame");

	a_close_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.event_kind == EV_CLOSE
		|-> res.payload_byte == 8'd0 && !res.is_binary && !res.last_of_frame)
		else $error("close event carries payload fields");

endmodule

>>> rtl/core/wsfp_out_buf.sv
// ----------------------------------------------------------------------------
// wsfp_out_buf
// Output register with skid stage; space flag does not depend on m_tready.
// ----------------------------------------------------------------------------
module wsfp_out_buf import wsfp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  wsfp_result_t wr_data,
	output logic         space,
	output logic         m_tvalid,
	input  logic         m_tready,
	output wsfp_result_t m_data
);

	logic         main_valid_q;
	logic         skid_valid_q;
	wsfp_result_t main_q;
	wsfp_result_t skid_q;
	logic         drain;

	assign space    = !skid_valid_q;
	assign m_tvalid = main_valid_q;
	assign m_data   = main_q;
	assign drain    = main_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				if (drain) begin
					skid_valid_q <= 1'b0;
				end
			end else if (wr) begin
				if (main_valid_q && !m_tready) begin
					skid_valid_q <= 1'b1;
				end else begin
					main_valid_q <= 1'b1;
				end
			end else if (drain) begin
				main_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain) begin
				main_q <= skid_q;
			end
		end else if (wr) begin
			if (main_valid_q && !m_tready) begin
				skid_q <= wr_data;
			end else begin
				main_q <= wr_data;
			end
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid full while output register empty");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> space)
		else $error("write into full output buffer");

endmodule
